/* src/dtte_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dtte_pkg: shared definitions for the timestamp text to epoch core
// Field widths, character codes, calendar constants and the
// controller/datapath command and status types.
// ----------------------------------------------------------------------------
package dtte_pkg;

  // payload widths
  localparam int CHAR_W  = 8;
  localparam int ZONE_W  = 17;
  localparam int EPOCH_W = 33;

  // per-part length limits
  localparam int DATE_MAX_CHARS = 10;
  localparam int TIME_MAX_CHARS = 8;

  // saturating counters and accumulator
  localparam int CNT_W   = 4;
  localparam int ACC_W   = 14;
  localparam int ACC_MAX = 16383;

  // closed field widths (year held as year minus 1900)
  localparam int YEAR_W   = 8;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] SEP_DATE  = 8'h2F;  // '/'
  localparam logic [CHAR_W-1:0] SEP_TIME  = 8'h3A;  // ':'

  // part select codes
  localparam logic PART_DATE = 1'b0;
  localparam logic PART_TIME = 1'b1;

  // field index codes
  localparam logic [1:0] FLD_FIRST  = 2'd0;
  localparam logic [1:0] FLD_SECOND = 2'd1;
  localparam logic [1:0] FLD_THIRD  = 2'd2;

  // year window
  localparam int YEAR_SHORT_MIN = 80;
  localparam int YEAR_SHORT_MAX = 99;
  localparam int YEAR_LONG_MIN  = 1970;
  localparam int YEAR_LONG_MAX  = 2095;
  localparam int YEAR_BASE      = 1900;

  // civil calendar constants
  localparam int ERA_DAYS     = 146097;
  localparam int CIVIL_SHIFT  = 719468;
  localparam int DAY_SECONDS  = 86400;

  // one closed stamp, handed from the parser to the arithmetic
  typedef struct packed {
    logic                ok;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } stamp_t;

  // controller commands
  typedef struct packed {
    logic take;        // character transfer this cycle
    logic snap;        // final character: capture the stamp
    logic calc_doy;
    logic calc_days;
    logic calc_scale;
    logic load_out;
  } ctrl_cmd_t;

  // controller status inputs
  typedef struct packed {
    logic in_valid;
    logic in_last;     // time part, last character
    logic out_free;
  } ctrl_status_t;

  // days before the shifted month (March = 0): (153*mp+2)/5
  function automatic logic [8:0] days_before_month(input logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

/* src/dtte_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dtte_in_if: character channel
// Valid/ready channel carrying one timestamp character and its part flags.
// ----------------------------------------------------------------------------
interface dtte_in_if;
  import dtte_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              part_sel;
  logic              part_end;

  modport source (output valid, char_code, part_sel, part_end, input ready);
  modport sink   (input valid, char_code, part_sel, part_end, output ready);
endinterface
`default_nettype wire

/* src/dtte_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dtte_out_if: result channel
// Valid/ready channel carrying the stamp flag and epoch seconds.
// ----------------------------------------------------------------------------
interface dtte_out_if;
  import dtte_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      stamp_valid;
  logic signed [EPOCH_W-1:0] epoch_seconds;

  modport source (output valid, stamp_valid, epoch_seconds, input ready);
  modport sink   (input valid, stamp_valid, epoch_seconds, output ready);
endinterface
`default_nettype wire

/* src/dtte_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dtte_ctrl: sequencing controller
// Accepts characters while idle and steps the epoch arithmetic through its
// stages after the last character of a time part.
// ----------------------------------------------------------------------------
module dtte_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dtte_pkg::ctrl_status_t status,
  output logic                   in_ready,
  output dtte_pkg::ctrl_cmd_t    cmd
);
  import dtte_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOY,
    ST_DAYS,
    ST_SCALE,
    ST_LOAD
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r;
  logic   take;

  assign take = ready_r & status.in_valid;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (take && status.in_last) state_nxt = ST_DOY;
      ST_DOY:   state_nxt = ST_DAYS;
      ST_DAYS:  state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_LOAD;
      ST_LOAD:  if (status.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= (state_nxt == ST_IDLE);
    end
  end

  assign in_ready       = ready_r;
  assign cmd.take       = take;
  assign cmd.snap       = take & status.in_last;
  assign cmd.calc_doy   = (state_r == ST_DOY);
  assign cmd.calc_days  = (state_r == ST_DAYS);
  assign cmd.calc_scale = (state_r == ST_SCALE);
  assign cmd.load_out   = (state_r == ST_LOAD) & status.out_free;

endmodule
`default_nettype wire

/* src/dtte_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dtte_parser: character parser
// Splits each part into three decimal fields, range checks them as they
// close and keeps the sticky failure flag for the current stamp.
// ----------------------------------------------------------------------------
module dtte_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dtte_pkg::ctrl_cmd_t           cmd,
  input  logic [dtte_pkg::CHAR_W-1:0]   char_code,
  input  logic                          part_sel,
  input  logic                          part_end,
  output dtte_pkg::stamp_t              stamp
);
  import dtte_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] DATE_LIM  = CNT_W'(DATE_MAX_CHARS);
  localparam logic [CNT_W-1:0] TIME_LIM  = CNT_W'(TIME_MAX_CHARS);
  localparam int               ACC_WIDE  = ACC_W + 4;

  typedef struct packed {
    logic [CNT_W-1:0]    part_cnt;
    logic [1:0]          fn;
    logic [CNT_W-1:0]    dig_cnt;
    logic [ACC_W-1:0]    acc;
    logic                cpl;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic                fail;
    logic                date_seen;
  } parse_t;

  parse_t st_r, st_nxt;

  // close the open field: check it, save it and move to the next one
  function automatic parse_t close_field(input parse_t s, input logic is_time);
    parse_t           r;
    logic [ACC_W-1:0] v;
    logic             good;
    logic [ACC_W-1:0] yr;
    r    = s;
    v    = s.acc;
    good = 1'b0;
    yr   = v - ACC_W'(YEAR_BASE);
    if (s.dig_cnt != '0) begin
      if (!is_time) begin
        case (s.fn)
          FLD_FIRST: begin
            good = (v >= ACC_W'(YEAR_SHORT_MIN) && v <= ACC_W'(YEAR_SHORT_MAX)) ||
                   (v >= ACC_W'(YEAR_LONG_MIN) && v <= ACC_W'(YEAR_LONG_MAX));
            if (good) r.year = (v > ACC_W'(YEAR_SHORT_MAX)) ? yr[YEAR_W-1:0]
                                                           : v[YEAR_W-1:0];
          end
          FLD_SECOND: begin
            good = (v >= ACC_W'(1)) && (v <= ACC_W'(12));
            if (good) r.month = v[MONTH_W-1:0];
          end
          FLD_THIRD: begin
            good = (v >= ACC_W'(1)) && (v <= ACC_W'(31));
            if (good) r.day = v[DAY_W-1:0];
          end
          default: good = 1'b0;
        endcase
      end else begin
        case (s.fn)
          FLD_FIRST: begin
            good = (v <= ACC_W'(23));
            if (good) r.hour = v[HOUR_W-1:0];
          end
          FLD_SECOND: begin
            good = (v <= ACC_W'(59));
            if (good) r.minute = v[MINUTE_W-1:0];
          end
          FLD_THIRD: begin
            good = (v <= ACC_W'(59));
            if (good) r.second = v[SECOND_W-1:0];
          end
          default: good = 1'b0;
        endcase
      end
    end
    if (!good) r.fail = 1'b1;
    if (s.fn >= FLD_THIRD) r.cpl = 1'b1;
    else                   r.fn  = s.fn + 2'd1;
    r.dig_cnt = '0;
    r.acc     = '0;
    return r;
  endfunction

  // per-character update
  always_comb begin
    parse_t              s;
    logic                is_time;
    logic [CNT_W-1:0]    limit;
    logic [CHAR_W-1:0]   sep;
    logic [ACC_WIDE-1:0] acc_wide;
    logic [ACC_WIDE-1:0] digit;

    s        = st_r;
    is_time  = (part_sel == PART_TIME);
    limit    = is_time ? TIME_LIM : DATE_LIM;
    sep      = is_time ? SEP_TIME : SEP_DATE;
    digit    = ACC_WIDE'(char_code - CHAR_ZERO);
    acc_wide = ACC_WIDE'(st_r.acc) * ACC_WIDE'(10) + digit;

    // a date character opening a part starts a new stamp
    if (st_r.part_cnt == '0 && !is_time) begin
      s.fail      = 1'b0;
      s.date_seen = 1'b0;
    end
    if (is_time != s.date_seen) s.fail = 1'b1;
    if (st_r.part_cnt >= limit) s.fail = 1'b1;
    if (st_r.part_cnt != CNT_MAX) s.part_cnt = st_r.part_cnt + 1'b1;

    if (!st_r.cpl) begin
      if (char_code == sep) begin
        s = close_field(s, is_time);
      end else if (char_code < CHAR_ZERO || char_code > CHAR_NINE) begin
        s.fail = 1'b1;
      end else begin
        s.acc = (acc_wide > ACC_WIDE'(ACC_MAX)) ? ACC_W'(ACC_MAX) : acc_wide[ACC_W-1:0];
        if (st_r.dig_cnt != CNT_MAX) s.dig_cnt = st_r.dig_cnt + 1'b1;
      end
    end

    // end of part: the third field must close here or have closed already
    if (part_end && !s.cpl) begin
      if (s.fn == FLD_THIRD) s = close_field(s, is_time);
      else                   s.fail = 1'b1;
    end

    stamp.ok     = ~s.fail;
    stamp.year   = s.year;
    stamp.month  = s.month;
    stamp.day    = s.day;
    stamp.hour   = s.hour;
    stamp.minute = s.minute;
    stamp.second = s.second;

    if (part_end) begin
      s.part_cnt = '0;
      s.fn       = FLD_FIRST;
      s.dig_cnt  = '0;
      s.acc      = '0;
      s.cpl      = 1'b0;
      if (!is_time) begin
        s.date_seen = 1'b1;
      end else begin
        s.fail      = 1'b0;
        s.date_seen = 1'b0;
      end
    end

    st_nxt = s;
  end

  // parse state; saved field values are payload and take no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.part_cnt  <= '0;
      st_r.fn        <= FLD_FIRST;
      st_r.dig_cnt   <= '0;
      st_r.acc       <= '0;
      st_r.cpl       <= 1'b0;
      st_r.fail      <= 1'b0;
      st_r.date_seen <= 1'b0;
    end else if (cmd.take) begin
      st_r <= st_nxt;
    end else begin
      st_r <= st_r;
    end
  end

endmodule
`default_nettype wire

/* src/dtte_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dtte_datapath: epoch arithmetic and result register
// Zone register, stamp capture, day-of-era, day count, scaling to seconds
// and the output register of the result channel.
// ----------------------------------------------------------------------------
module dtte_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dtte_pkg::ctrl_cmd_t                 cmd,
  input  dtte_pkg::stamp_t                    stamp,
  input  logic                                cfg_wr_en,
  input  logic signed [dtte_pkg::ZONE_W-1:0]  cfg_wr_data,
  input  logic                                out_ready,
  output logic                                out_free,
  output logic                                out_valid,
  output logic                                out_stamp_valid,
  output logic signed [dtte_pkg::EPOCH_W-1:0] out_epoch
);
  import dtte_pkg::*;

  localparam int DAYS_W  = 17;
  localparam int TOD_W   = 17;
  localparam int SCALE_W = 32;
  localparam int SUM_W   = 21;
  localparam logic signed [SUM_W-1:0] ERA4_OFF = SUM_W'(4 * ERA_DAYS - CIVIL_SHIFT);
  localparam logic signed [SUM_W-1:0] ERA5_OFF = SUM_W'(5 * ERA_DAYS - CIVIL_SHIFT);

  logic signed [ZONE_W-1:0] zone_r;
  stamp_t                   snap_r;
  logic                     era5_r;
  logic [8:0]               yoe_r;
  logic [8:0]               doy_r;
  logic [TOD_W-1:0]         tod_r;
  logic [DAYS_W-1:0]        days_r;
  logic [SCALE_W-1:0]       scaled_r;
  logic                     out_valid_r;
  logic                     out_ok_r;
  logic [EPOCH_W-1:0]       out_epoch_r;

  logic [YEAR_W-1:0]  yy;
  logic               era5_nxt;
  logic [8:0]         yoe_nxt;
  logic [3:0]         mp;
  logic [8:0]         doy_nxt;
  logic [TOD_W-1:0]   tod_nxt;
  logic [17:0]        yoe365;
  logic [1:0]         cent;
  logic [SUM_W-1:0]   days_sum;
  logic [33:0]        prod;
  logic [EPOCH_W-1:0] epoch_nxt;

  // zone offset register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= '0;
    end else if (cfg_wr_en) begin
      zone_r <= cfg_wr_data;
    end
  end

  // stage 1: year of era, day of year, time of day
  always_comb begin
    yy       = snap_r.year - YEAR_W'(snap_r.month <= MONTH_W'(2));
    era5_nxt = (yy >= YEAR_W'(100));
    yoe_nxt  = era5_nxt ? 9'(yy) - 9'd100 : 9'(yy) + 9'd300;
    mp       = (snap_r.month >= MONTH_W'(3)) ? snap_r.month - 4'd3 : snap_r.month + 4'd9;
    doy_nxt  = days_before_month(mp) + 9'(snap_r.day) - 9'd1;
    tod_nxt  = TOD_W'(snap_r.hour) * TOD_W'(3600) + TOD_W'(snap_r.minute) * TOD_W'(60)
             + TOD_W'(snap_r.second);
  end

  // stage 2: days since the epoch
  always_comb begin
    yoe365 = 18'(yoe_r) * 18'd365;
    if (yoe_r >= 9'd300)      cent = 2'd3;
    else if (yoe_r >= 9'd200) cent = 2'd2;
    else if (yoe_r >= 9'd100) cent = 2'd1;
    else                      cent = 2'd0;
    days_sum = (era5_r ? ERA5_OFF : ERA4_OFF) + SUM_W'(yoe365) + SUM_W'(yoe_r >> 2)
             - SUM_W'(cent) + SUM_W'(doy_r);
  end

  // stage 3: scale to seconds; stage 4: add time of day, take off the zone
  assign prod      = 34'(days_r) * 34'(DAY_SECONDS);
  assign epoch_nxt = EPOCH_W'(scaled_r) + EPOCH_W'(tod_r)
                   - {{(EPOCH_W-ZONE_W){zone_r[ZONE_W-1]}}, zone_r};

  // arithmetic stages
  always_ff @(posedge clk) begin
    if (cmd.snap) snap_r <= stamp;
    if (cmd.calc_doy) begin
      era5_r <= era5_nxt;
      yoe_r  <= yoe_nxt;
      doy_r  <= doy_nxt;
      tod_r  <= tod_nxt;
    end
    if (cmd.calc_days)  days_r   <= days_sum[DAYS_W-1:0];
    if (cmd.calc_scale) scaled_r <= prod[SCALE_W-1:0];
  end

  // result register: holds until the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ok_r    <= snap_r.ok;
      out_epoch_r <= snap_r.ok ? epoch_nxt : '0;
    end
  end

  assign out_free        = ~out_valid_r | out_ready;
  assign out_valid       = out_valid_r;
  assign out_stamp_valid = out_ok_r;
  assign out_epoch       = $signed(out_epoch_r);

endmodule
`default_nettype wire

/* src/date_time_text_to_epoch_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// date_time_text_to_epoch_core: timestamp text to epoch seconds
// Parses "year/month/day" then "hour:minute:second" one character per
// transfer and returns a valid flag with seconds since 1970-01-01 UTC.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle while idle. The last character of a
// time part starts the epoch arithmetic (day of era, day count, scaling by
// 86400, time of day and zone), four steps in a shared datapath, with the
// input closed meanwhile; the result then sits in an output register while
// parsing of the next stamp goes on, and the input waits longer only if the
// previous result has not yet been taken. The user must write the zone
// offset via cfg_wr_en/cfg_wr_data while the block is idle; it never checks.
// ----------------------------------------------------------------------------
module date_time_text_to_epoch_core (
  input  logic                               clk,
  input  logic                               rst_n,
  dtte_in_if.sink                            in_chan,
  dtte_out_if.source                         out_chan,
  input  logic                               cfg_wr_en,
  input  logic signed [dtte_pkg::ZONE_W-1:0] cfg_wr_data
);
  import dtte_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;
  stamp_t       stamp;
  logic         out_free;
  logic         in_ready;

  assign status.in_valid = in_chan.valid;
  assign status.in_last  = (in_chan.part_sel == PART_TIME) & in_chan.part_end;
  assign status.out_free = out_free;
  assign in_chan.ready   = in_ready;

  // sequencing
  dtte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // character parsing
  dtte_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .char_code (in_chan.char_code),
    .part_sel  (in_chan.part_sel),
    .part_end  (in_chan.part_end),
    .stamp     (stamp)
  );

  // epoch arithmetic and result register
  dtte_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stamp           (stamp),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_ready       (out_chan.ready),
    .out_free        (out_free),
    .out_valid       (out_chan.valid),
    .out_stamp_valid (out_chan.stamp_valid),
    .out_epoch       (out_chan.epoch_seconds)
  );

`ifndef NO_ASSERTIONS
  // the last time character closes the input until the result is loaded
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.snap |=> !in_chan.ready)
    else $error("input still open after the last time character");

  // arithmetic steps follow one another
  a_step_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc_doy |=> cmd.calc_days ##1 cmd.calc_scale)
    else $error("epoch arithmetic steps out of order");

  // after scaling the result loads as soon as the output register is free
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc_scale |=> (cmd.load_out == status.out_free))
    else $error("result load does not follow output space");

  // a rejected stamp carries zero seconds
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.stamp_valid) |-> (out_chan.epoch_seconds == '0))
    else $error("rejected stamp with non-zero seconds");
`endif

endmodule
`default_nettype wire

/* bench/dtte_stamp_checker.sv */
// ----------------------------------------------------------------------------
// dtte_stamp_checker: result predictor and scoreboard for the timestamp core
// Watches the character, result and zone ports, keeps its own copy of the
// parse state, works out each stamp's flag and epoch seconds, and compares
// every result transfer against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module dtte_stamp_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  dtte_in_if                                  in_chan,
  dtte_out_if                                 out_chan,
  input  logic                                cfg_wr_en,
  input  logic signed [dtte_pkg::ZONE_W-1:0]  cfg_wr_data,
  output int                                  outstanding,
  output int                                  fail_count
);
  import dtte_pkg::*;

  localparam logic [CNT_W-1:0] CNT_SAT    = '1;

  typedef struct packed {
    logic               ok;
    logic [EPOCH_W-1:0] secs;
  } stamp_result_t;

  stamp_result_t expected_stamps[$];

  // zone register copy
  logic signed [ZONE_W-1:0] zone_offset;

  // parse state of the stamp in flight
  logic [CNT_W-1:0]    chars_in_part;
  logic [1:0]          open_field;
  logic [CNT_W-1:0]    field_digits;
  logic [ACC_W-1:0]    field_value;
  logic                part_closed;
  logic [YEAR_W-1:0]   stamp_year;     // year minus 1900
  logic [MONTH_W-1:0]  stamp_month;
  logic [DAY_W-1:0]    stamp_day;
  logic [HOUR_W-1:0]   stamp_hour;
  logic [MINUTE_W-1:0] stamp_minute;
  logic [SECOND_W-1:0] stamp_second;
  logic                stamp_bad;
  logic                date_done;

  function automatic void clear_part();
    chars_in_part = '0;
    open_field    = FLD_FIRST;
    field_digits  = '0;
    field_value   = '0;
    part_closed   = 1'b0;
  endfunction

  function automatic void clear_stamp();
    clear_part();
    stamp_year   = '0;
    stamp_month  = '0;
    stamp_day    = '0;
    stamp_hour   = '0;
    stamp_minute = '0;
    stamp_second = '0;
    stamp_bad    = 1'b0;
    date_done    = 1'b0;
  endfunction

  // range check and capture of the open field, then move to the next one
  function automatic void close_field(input logic sel);
    int   v;
    logic fits;
    v    = int'(field_value);
    fits = 1'b0;
    if (field_digits != 0) begin
      if (sel == PART_DATE) begin
        case (open_field)
          FLD_FIRST: begin
            fits = (v >= YEAR_SHORT_MIN && v <= YEAR_SHORT_MAX) ||
                   (v >= YEAR_LONG_MIN && v <= YEAR_LONG_MAX);
            if (fits) stamp_year = YEAR_W'((v >= YEAR_LONG_MIN) ? v - YEAR_BASE : v);
          end
          FLD_SECOND: begin
            fits = (v >= 1 && v <= 12);
            if (fits) stamp_month = MONTH_W'(v);
          end
          FLD_THIRD: begin
            fits = (v >= 1 && v <= 31);
            if (fits) stamp_day = DAY_W'(v);
          end
          default: fits = 1'b0;
        endcase
      end else begin
        case (open_field)
          FLD_FIRST: begin
            fits = (v <= 23);
            if (fits) stamp_hour = HOUR_W'(v);
          end
          FLD_SECOND: begin
            fits = (v <= 59);
            if (fits) stamp_minute = MINUTE_W'(v);
          end
          FLD_THIRD: begin
            fits = (v <= 59);
            if (fits) stamp_second = SECOND_W'(v);
          end
          default: fits = 1'b0;
        endcase
      end
    end
    if (!fits) stamp_bad = 1'b1;
    if (open_field >= FLD_THIRD) part_closed = 1'b1;
    else open_field = open_field + 2'd1;
    field_digits = '0;
    field_value  = '0;
  endfunction

  // days from 1970-01-01 to a proleptic Gregorian date
  function automatic longint civil_days(input int year, input int month, input int day);
    longint y, era, yoe, mp, doy, doe;
    y   = year - ((month <= 2) ? 1 : 0);
    era = y / 400;
    yoe = y - era * 400;
    mp  = (month + 9) % 12;
    doy = (153 * mp + 2) / 5 + day - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * ERA_DAYS + doe - CIVIL_SHIFT;
  endfunction

  // one character in; returns 1 when it closes a stamp, with its result
  function automatic logic predict_char(input logic [CHAR_W-1:0] code, input logic sel,
                                        input logic fin, output stamp_result_t res);
    int                limit, a;
    logic [CHAR_W-1:0] sep;
    longint            days, total;
    res   = '0;
    limit = (sel == PART_TIME) ? TIME_MAX_CHARS : DATE_MAX_CHARS;
    sep   = (sel == PART_TIME) ? SEP_TIME : SEP_DATE;
    // a date character opening a part starts a fresh stamp
    if (chars_in_part == 0 && sel == PART_DATE) begin
      stamp_bad = 1'b0;
      date_done = 1'b0;
    end
    // time needs a finished date; a date character may not cut into time
    if (sel != date_done) stamp_bad = 1'b1;
    if (chars_in_part >= limit) stamp_bad = 1'b1;
    if (chars_in_part != CNT_SAT) chars_in_part = chars_in_part + 1'b1;
    // text after the third separator is ignored
    if (!part_closed) begin
      if (code == sep) begin
        close_field(sel);
      end else if (code < CHAR_ZERO || code > CHAR_NINE) begin
        stamp_bad = 1'b1;
      end else begin
        a = int'(field_value) * 10 + int'(code - CHAR_ZERO);
        field_value = ACC_W'((a > ACC_MAX) ? ACC_MAX : a);
        if (field_digits != CNT_SAT) field_digits = field_digits + 1'b1;
      end
    end
    if (!fin) return 1'b0;
    if (!part_closed) begin
      if (open_field == FLD_THIRD) close_field(sel);
      else stamp_bad = 1'b1;
    end
    if (sel == PART_DATE) begin
      date_done = 1'b1;
      clear_part();
      return 1'b0;
    end
    res.ok = !stamp_bad;
    if (res.ok) begin
      days  = civil_days(int'(stamp_year) + YEAR_BASE, int'(stamp_month), int'(stamp_day));
      total = days * DAY_SECONDS + longint'(stamp_hour) * 3600
            + longint'(stamp_minute) * 60 + longint'(stamp_second)
            - longint'(zone_offset);
      res.secs = total[EPOCH_W-1:0];
    end
    clear_stamp();
    return 1'b1;
  endfunction

  // predict on character transfers, compare on result transfers
  always @(posedge clk) begin
    stamp_result_t want;
    if (!rst_n) begin
      clear_stamp();
      zone_offset = '0;
      expected_stamps.delete();
      fail_count  = 0;
      outstanding <= 0;
    end else begin
      if (cfg_wr_en) zone_offset = cfg_wr_data;
      if (in_chan.valid && in_chan.ready) begin
        if (predict_char(in_chan.char_code, in_chan.part_sel, in_chan.part_end, want))
          expected_stamps.push_back(want);
      end
      if (out_chan.valid && out_chan.ready) begin
        if (expected_stamps.size() == 0) begin
          $error("unexpected result: stamp_valid %0d epoch_seconds %0d",
                 out_chan.stamp_valid, out_chan.epoch_seconds);
          fail_count++;
        end else begin
          want = expected_stamps.pop_front();
          if (out_chan.stamp_valid !== want.ok) begin
            $error("stamp_valid: expected %0d, got %0d", want.ok, out_chan.stamp_valid);
            fail_count++;
          end
          if (out_chan.epoch_seconds !== want.secs) begin
            $error("epoch_seconds: expected %0d, got %0d",
                   $signed(want.secs), out_chan.epoch_seconds);
            fail_count++;
          end
        end
      end
      outstanding <= expected_stamps.size();
    end
  end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the timestamp text to epoch core
// Sends directed stamps covering field limits, length limits, bad text and
// part ordering, then random stamps (mostly well formed, some corrupted)
// over several zone offsets, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import dtte_pkg::*;

  localparam int IDLE_PCT     = 17;
  localparam int RANDOM_CHARS = 1500;
  localparam int PHASES       = 5;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT  = 2000;
  localparam int ZONE_MIN     = -50400;
  localparam int ZONE_MAX     = 50400;
  localparam int YEAR_EDGES[8] = '{79, 80, 99, 100, 1969, 1970, 2095, 2096};

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              sel;
    logic              part_end;
  } text_char_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic signed [ZONE_W-1:0] cfg_wr_data = '0;
  logic result_ready = 1'b0;
  logic calm = 1'b0;
  int   chars_sent = 0;
  int   quiet_cycles = 0;
  int   outstanding;
  int   fail_count;

  text_char_t stamp_chars[$];

  dtte_in_if  in_chan ();
  dtte_out_if out_chan ();

  assign out_chan.ready = result_ready;

  date_time_text_to_epoch_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  dtte_stamp_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  always #10 clk = ~clk;

  // result side back-pressure
  always @(posedge clk) begin
    result_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // watchdog: too long without any transfer
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one character transfer, with a random gap in front
  task automatic send_char(input logic [CHAR_W-1:0] code, input logic sel, input logic fin);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.char_code <= code;
    in_chan.part_sel  <= sel;
    in_chan.part_end  <= fin;
    do @(posedge clk); while (!in_chan.ready);
    chars_sent++;
  endtask

  function automatic void add_part(input string s, input logic sel);
    for (int i = 0; i < s.len(); i++)
      stamp_chars.push_back('{code: s[i], sel: sel, part_end: (i == s.len() - 1)});
  endfunction

  task automatic send_stamp_chars();
    foreach (stamp_chars[i])
      send_char(stamp_chars[i].code, stamp_chars[i].sel, stamp_chars[i].part_end);
    stamp_chars.delete();
  endtask

  // an empty string leaves that part out
  task automatic send_text_stamp(input string date_txt, input string time_txt);
    stamp_chars.delete();
    if (date_txt.len() != 0) add_part(date_txt, PART_DATE);
    if (time_txt.len() != 0) add_part(time_txt, PART_TIME);
    send_stamp_chars();
  endtask

  // a random stamp: mostly in range and well formed, sometimes damaged
  task automatic random_stamp();
    int    yr, mo, dy, hh, mm, ss, idx, pick;
    string date_txt, time_txt;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: yr = $urandom_range(YEAR_SHORT_MIN, YEAR_SHORT_MAX);
      4, 5, 6, 7: yr = $urandom_range(YEAR_LONG_MIN, YEAR_LONG_MAX);
      8:          yr = YEAR_EDGES[$urandom_range(0, 7)];
      default:    yr = $urandom_range(0, 99999);
    endcase
    mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
    dy = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 39) : $urandom_range(1, 31);
    hh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23);
    mm = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
    ss = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
    if ($urandom_range(0, 1) != 0) date_txt = $sformatf("%0d/%02d/%02d", yr, mo, dy);
    else date_txt = $sformatf("%0d/%0d/%0d", yr, mo, dy);
    if ($urandom_range(0, 1) != 0) time_txt = $sformatf("%02d:%02d:%02d", hh, mm, ss);
    else time_txt = $sformatf("%0d:%0d:%0d", hh, mm, ss);
    // trailing text after a closing separator
    if ($urandom_range(0, 19) == 0)
      date_txt = $sformatf("%s/%c", date_txt, 8'($urandom_range(33, 126)));
    if ($urandom_range(0, 19) == 0)
      time_txt = $sformatf("%s:%0d", time_txt, $urandom_range(0, 9));

    stamp_chars.delete();
    if ($urandom_range(0, 99) >= 8) add_part(date_txt, PART_DATE);
    add_part(time_txt, PART_TIME);

    idx  = $urandom_range(0, stamp_chars.size() - 1);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      stamp_chars[idx].code = 8'($urandom_range(0, 255));
    end else if (pick < 14 && stamp_chars.size() > 1) begin
      stamp_chars.delete(idx);
    end else if (pick < 20) begin
      stamp_chars.insert(idx, '{code: 8'($urandom_range(0, 255)),
                                sel: stamp_chars[idx].sel, part_end: 1'b0});
    end else if (pick < 24) begin
      stamp_chars[idx].sel = ~stamp_chars[idx].sel;
    end else if (pick < 28) begin
      stamp_chars[idx].part_end = ~stamp_chars[idx].part_end;
    end else if (pick < 33) begin
      // loose noise ahead of the stamp
      repeat ($urandom_range(1, 6))
        stamp_chars.insert(0, '{code: 8'($urandom_range(0, 255)),
                                sel: 1'($urandom_range(0, 1)),
                                part_end: 1'($urandom_range(0, 1))});
    end
    send_stamp_chars();
  endtask

  // hold the sender until every result is in and the core has gone quiet
  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_zone(input int secs);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ZONE_W'(secs);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int target, zone;
    in_chan.valid     = 1'b0;
    in_chan.char_code = '0;
    in_chan.part_sel  = PART_DATE;
    in_chan.part_end  = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_zone(19800);

    // directed: field limits and extremes
    send_text_stamp("80/1/1", "0:0:0");
    send_text_stamp("2095/12/31", "23:59:59");
    send_text_stamp("1970/01/01", "00:00:00");
    send_text_stamp("99/2/31", "12:30:45");      // rolls into March
    send_text_stamp("79/1/1", "1:1:1");
    send_text_stamp("100/1/1", "1:1:1");
    send_text_stamp("1969/12/31", "23:59:59");
    send_text_stamp("2096/1/1", "0:0:0");
    send_text_stamp("2000/0/1", "0:0:0");
    send_text_stamp("2000/13/1", "0:0:0");
    send_text_stamp("2000/1/0", "0:0:0");
    send_text_stamp("2000/1/32", "0:0:0");
    send_text_stamp("2000/1/1", "24:0:0");
    send_text_stamp("2000/1/1", "0:60:0");
    send_text_stamp("2000/1/1", "0:0:60");
    // directed: text shape
    send_text_stamp("2000/01/015", "1:2:3");     // date part too long
    send_text_stamp("2000/1/1", "00:00:000");    // time part too long
    send_text_stamp("20a0/1/1", "1:2:3");        // stray letter
    send_text_stamp("2000//1", "1:2:3");         // empty field
    send_text_stamp("2000/1", "1:2:3");          // third field never opened
    send_text_stamp("", "1:2:3");                // time without a date
    send_text_stamp("2000/1/1/x", "1:2:3:");     // ignored tail
    send_text_stamp("99999/1/1", "1:2:3");       // accumulator saturates
    // date character cutting into the time part
    add_part("2001/2/3", PART_DATE);
    add_part("1:2:3", PART_TIME);
    stamp_chars.insert(stamp_chars.size() - 3, '{code: "5", sel: PART_DATE, part_end: 1'b0});
    send_stamp_chars();
    // all-zero and all-one character codes
    add_part("2000/1/1", PART_DATE);
    stamp_chars[2].code = 8'hFF;
    add_part("0:0:0", PART_TIME);
    stamp_chars[stamp_chars.size() - 2].code = 8'h00;
    send_stamp_chars();

    // random stamps, one zone setting per phase
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0:       zone = ZONE_MIN;
        1:       zone = ZONE_MAX;
        4:       zone = 0;
        default: zone = int'($urandom_range(0, ZONE_MAX - ZONE_MIN)) + ZONE_MIN;
      endcase
      write_zone(zone);
      calm   = (phase == 2);   // one long run with no idling
      target = chars_sent + RANDOM_CHARS / PHASES;
      while (chars_sent < target) random_stamp();
    end
    calm = 1'b0;
    settle();

    if (fail_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
